@@ src/thnf_pkg.sv @@
// Shared types and constants of the telnet-aware Hangul noise filter.
// Used by the front, queue and back modules and by the top level.
// Depends on nothing.
package thnf_pkg;

    // Saturating byte counter width and width of the count port
    localparam int COUNT_BITS  = 16;
    localparam int OUT_COUNT_W = 16;

    // Action queue between front and back (depth is a power of two)
    localparam int ACT_DEPTH = 4;
    localparam int ACT_PTR_W = $clog2(ACT_DEPTH);

    // Byte classes
    localparam logic [7:0] BYTE_IAC       = 8'd255;
    localparam logic [7:0] LEAD_MIN       = 8'd160;
    localparam logic [7:0] LEAD_MAX       = 8'd200;
    localparam logic [7:0] TRAIL_MAX      = 8'd254;
    localparam logic [7:0] OPT_CMD_MIN    = 8'd251;
    localparam logic [7:0] OPT_CMD_MAX    = 8'd254;
    localparam logic [7:0] TEXT_MIN       = 8'h20;
    localparam logic [7:0] TEXT_MAX       = 8'h7e;
    localparam logic [7:0] CHAR_NL        = 8'h0a;
    localparam logic [7:0] CHAR_CR        = 8'h0d;
    localparam logic [7:0] CHAR_TAB       = 8'h09;
    localparam logic [7:0] CMD_MIN_RESET  = 8'd236;

    typedef logic [COUNT_BITS-1:0]  count_t;
    typedef logic [COUNT_BITS:0]    count_sum_t;
    typedef logic [OUT_COUNT_W-1:0] count_out_t;
    typedef logic [ACT_PTR_W-1:0]   act_ptr_t;
    typedef logic [ACT_PTR_W:0]     act_fill_t;

    localparam count_t COUNT_MAX = '1;

    // One classified input byte: up to two bytes to emit, then an optional end word
    typedef struct packed {
        logic [1:0] nbytes;
        logic [7:0] b0;
        logic [7:0] b1;
        logic       has_end;
        count_out_t count;
    } act_t;

endpackage

@@ src/thnf_front.sv @@
// Front part: classifies each input byte and tracks lead/IAC/option mode.
// Holds the cmd_min register and the saturating byte counter.
// Depends on thnf_pkg.
module thnf_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_valid,
    input  logic [7:0]          cfg_data,
    input  logic                push,
    input  logic [7:0]          in_byte,
    input  logic                in_last,
    input  logic                q_full,
    output logic                q_wr,
    output thnf_pkg::act_t      q_data
);

    typedef enum logic [1:0] {
        MODE_READY,
        MODE_LEAD,
        MODE_IAC,
        MODE_OPTION
    } mode_t;

    mode_t            mode_reg, mode_next;
    logic [7:0]       held_reg, held_next;
    logic [7:0]       cmd_min_reg;
    thnf_pkg::count_t count_reg, count_next;

    logic             accept;
    logic             as_ready;
    logic             is_text;
    logic [1:0]       nb;
    logic [7:0]       b0, b1;
    thnf_pkg::count_sum_t count_sum;
    thnf_pkg::count_t     count_sat;

    assign accept = push && !q_full;

    // Printable ASCII, newline, carriage return, tab
    assign is_text = (in_byte >= thnf_pkg::TEXT_MIN && in_byte <= thnf_pkg::TEXT_MAX)
                  || in_byte == thnf_pkg::CHAR_NL || in_byte == thnf_pkg::CHAR_CR
                  || in_byte == thnf_pkg::CHAR_TAB;

    // Classify the byte against the current mode
    always_comb
    begin
        mode_next = mode_reg;
        held_next = held_reg;
        nb        = 2'd0;
        b0        = 8'd0;
        b1        = 8'd0;
        as_ready  = 1'b0;
        case (mode_reg)
            MODE_LEAD:
            begin
                if (in_byte == thnf_pkg::BYTE_IAC)
                begin
                    held_next = thnf_pkg::BYTE_IAC;
                    mode_next = MODE_IAC;
                end
                else if (in_byte >= thnf_pkg::LEAD_MIN && in_byte <= thnf_pkg::TRAIL_MAX)
                begin
                    nb        = 2'd2;
                    b0        = held_reg;
                    b1        = in_byte;
                    mode_next = MODE_READY;
                end
                else if (is_text)
                begin
                    nb        = 2'd1;
                    b0        = in_byte;
                    mode_next = MODE_READY;
                end
            end
            MODE_IAC:
            begin
                if (in_byte >= cmd_min_reg)
                begin
                    nb = 2'd2;
                    b0 = thnf_pkg::BYTE_IAC;
                    b1 = in_byte;
                    if (in_byte >= thnf_pkg::OPT_CMD_MIN && in_byte <= thnf_pkg::OPT_CMD_MAX)
                        mode_next = MODE_OPTION;
                    else
                        mode_next = MODE_READY;
                end
                else
                begin
                    // Drop the 255 and reprocess the byte from ready
                    mode_next = MODE_READY;
                    as_ready  = 1'b1;
                end
            end
            MODE_OPTION:
            begin
                nb        = 2'd1;
                b0        = in_byte;
                mode_next = MODE_READY;
            end
            default:
            begin
                as_ready = 1'b1;
            end
        endcase

        if (as_ready)
        begin
            if (in_byte == thnf_pkg::BYTE_IAC)
            begin
                held_next = thnf_pkg::BYTE_IAC;
                mode_next = MODE_IAC;
            end
            else if (is_text)
            begin
                nb = 2'd1;
                b0 = in_byte;
            end
            else if (in_byte >= thnf_pkg::LEAD_MIN && in_byte <= thnf_pkg::LEAD_MAX)
            begin
                held_next = in_byte;
                mode_next = MODE_LEAD;
            end
        end
    end

    // Advance the saturating count by the bytes emitted
    always_comb
    begin
        count_sum = thnf_pkg::count_sum_t'(count_reg) + thnf_pkg::count_sum_t'(nb);
        if (count_sum > thnf_pkg::count_sum_t'(thnf_pkg::COUNT_MAX))
            count_sat = thnf_pkg::COUNT_MAX;
        else
            count_sat = thnf_pkg::count_t'(count_sum);
        count_next = in_last ? '0 : count_sat;
    end

    // Build the action word for the queue
    always_comb
    begin
        q_data.nbytes  = nb;
        q_data.b0      = b0;
        q_data.b1      = b1;
        q_data.has_end = in_last;
        q_data.count   = thnf_pkg::count_out_t'(count_sat);
        q_wr           = accept && (nb != 2'd0 || in_last);
    end

    // Hold mode, held byte, count and cmd_min
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg    <= MODE_READY;
            held_reg    <= 8'd0;
            count_reg   <= '0;
            cmd_min_reg <= thnf_pkg::CMD_MIN_RESET;
        end
        else
        begin
            if (cfg_valid)
                cmd_min_reg <= cfg_data;
            if (accept)
            begin
                count_reg <= count_next;
                if (in_last)
                begin
                    mode_reg <= MODE_READY;
                    held_reg <= 8'd0;
                end
                else
                begin
                    mode_reg <= mode_next;
                    held_reg <= held_next;
                end
            end
        end
    end

endmodule

@@ src/thnf_queue.sv @@
// Short action queue between the front and back parts.
// Depends on thnf_pkg.
module thnf_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           wr_en,
    input  thnf_pkg::act_t wr_data,
    output logic           full,
    input  logic           rd_en,
    output logic           rd_valid,
    output thnf_pkg::act_t rd_data
);

    thnf_pkg::act_t      mem_reg [thnf_pkg::ACT_DEPTH];
    thnf_pkg::act_ptr_t  wr_ptr_reg, rd_ptr_reg;
    thnf_pkg::act_fill_t fill_reg;

    logic do_wr, do_rd;

    assign full     = (fill_reg == thnf_pkg::act_fill_t'(thnf_pkg::ACT_DEPTH));
    assign rd_valid = (fill_reg != '0);
    assign rd_data  = mem_reg[rd_ptr_reg];
    assign do_wr    = wr_en && !full;
    assign do_rd    = rd_en && rd_valid;

    // Store incoming actions
    always_ff @(posedge clk)
    begin
        if (do_wr)
            mem_reg[wr_ptr_reg] <= wr_data;
    end

    // Advance pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            if (do_wr)
                wr_ptr_reg <= wr_ptr_reg + thnf_pkg::act_ptr_t'(1);
            if (do_rd)
                rd_ptr_reg <= rd_ptr_reg + thnf_pkg::act_ptr_t'(1);
            if (do_wr && !do_rd)
                fill_reg <= fill_reg + thnf_pkg::act_fill_t'(1);
            else if (do_rd && !do_wr)
                fill_reg <= fill_reg - thnf_pkg::act_fill_t'(1);
        end
    end

endmodule

@@ src/thnf_back.sv @@
// Back part: expands each action into result words, one per cycle while the
// receiver keeps popping, into a single output register. Depends on thnf_pkg.
module thnf_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 q_valid,
    input  thnf_pkg::act_t       q_data,
    output logic                 q_rd,
    output logic                 empty,
    input  logic                 pop,
    output logic [7:0]           out_byte,
    output logic                 run_last,
    output logic                 msg_end,
    output thnf_pkg::count_out_t out_count
);

    thnf_pkg::act_t       cur_reg;
    logic                 cur_valid_reg;
    logic [1:0]           idx_reg;
    logic                 out_valid_reg;
    logic [7:0]           out_byte_reg;
    logic                 run_last_reg;
    logic                 msg_end_reg;
    thnf_pkg::count_out_t out_count_reg;

    logic [1:0] total;
    logic       load, step, finish, fetch;
    logic       is_end;

    assign total  = cur_reg.nbytes + {1'b0, cur_reg.has_end};
    assign load   = !out_valid_reg || pop;
    assign step   = cur_valid_reg && load;
    assign finish = step && (idx_reg == total - 2'd1);
    assign fetch  = q_valid && (!cur_valid_reg || finish);
    assign q_rd   = fetch;
    assign is_end = (idx_reg >= cur_reg.nbytes);

    assign empty     = !out_valid_reg;
    assign out_byte  = out_byte_reg;
    assign run_last  = run_last_reg;
    assign msg_end   = msg_end_reg;
    assign out_count = out_count_reg;

    // Walk the current action one word at a time
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg <= 1'b0;
            idx_reg       <= 2'd0;
        end
        else if (fetch)
        begin
            cur_valid_reg <= 1'b1;
            idx_reg       <= 2'd0;
        end
        else if (finish)
        begin
            cur_valid_reg <= 1'b0;
        end
        else if (step)
        begin
            idx_reg <= idx_reg + 2'd1;
        end
    end

    // Latch the next action
    always_ff @(posedge clk)
    begin
        if (fetch)
            cur_reg <= q_data;
    end

    // Hold the result word until it is popped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (step)
            out_valid_reg <= 1'b1;
        else if (pop)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            run_last_reg <= (idx_reg == total - 2'd1);
            msg_end_reg  <= is_end;
            if (is_end)
            begin
                out_byte_reg  <= 8'd0;
                out_count_reg <= cur_reg.count;
            end
            else
            begin
                out_byte_reg  <= (idx_reg == 2'd0) ? cur_reg.b0 : cur_reg.b1;
                out_count_reg <= '0;
            end
        end
    end

endmodule

@@ src/telnet_aware_hangul_noise_filter.sv @@
// Telnet-aware Hangul noise filter, top level.
// Instantiates thnf_front, thnf_queue and thnf_back; depends on thnf_pkg.
//
// Usage:
//   Input queue port: drive in_byte/in_last and raise push; the word is taken
//   at a clock edge with push high and full low. One byte is taken per cycle
//   while the action queue (4 entries) has room.
//   Result queue port: while empty is low, out_byte/run_last/msg_end/out_count
//   show the oldest result word; pop high at a clock edge takes it.
//   Each input byte yields zero, one or two byte words, plus an end word with
//   the saturated byte count when in_last is set; run_last marks the last word
//   an input caused.
//   Flow: an emitting byte is written to the action queue, latched into the
//   back part's current action and then into the output register. The back
//   part sends one result word per cycle while the receiver pops; an input
//   makes at most 3 words. Inputs arrive at one per cycle as long as the queue absorbs the burst.
//   Configuration: cmd_min is written at an edge with cfg_valid high;
//   cfg_ready is always high. Write it only while the block is idle.
//   Reset: rst_n low clears mode, held byte, count and all queues, and sets
//   cmd_min to 236. When the receiver stalls, the result word holds, the
//   queue fills and full rises; no word is lost.
module telnet_aware_hangul_noise_filter (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_data,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  in_byte,
    input  logic        in_last,
    output logic        empty,
    input  logic        pop,
    output logic [7:0]  out_byte,
    output logic        run_last,
    output logic        msg_end,
    output logic [15:0] out_count
);

    thnf_pkg::act_t wr_act, rd_act;
    logic           q_wr, q_rd, q_valid, q_full;

    assign cfg_ready = 1'b1;
    assign full      = q_full;

    // Classify input bytes
    thnf_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .push      (push),
        .in_byte   (in_byte),
        .in_last   (in_last),
        .q_full    (q_full),
        .q_wr      (q_wr),
        .q_data    (wr_act)
    );

    // Buffer actions between the two parts
    thnf_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (q_wr),
        .wr_data  (wr_act),
        .full     (q_full),
        .rd_en    (q_rd),
        .rd_valid (q_valid),
        .rd_data  (rd_act)
    );

    // Expand actions into result words
    thnf_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_data    (rd_act),
        .q_rd      (q_rd),
        .empty     (empty),
        .pop       (pop),
        .out_byte  (out_byte),
        .run_last  (run_last),
        .msg_end   (msg_end),
        .out_count (out_count)
    );

endmodule

@@ src/thnf_checker.sv @@
// Port-level checks for the telnet-aware Hangul noise filter.
// Bound to the top level below; depends on nothing else.
module thnf_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        empty,
    input logic        pop,
    input logic [7:0]  out_byte,
    input logic        run_last,
    input logic        msg_end,
    input logic [15:0] out_count
);

    // A stalled result word holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && !pop |=> !empty && $stable(out_byte) && $stable(msg_end)
            && $stable(out_count) && $stable(run_last))
        else $error("result word changed while stalled");

    // The end word is always the last word of its input
    a_end_last: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && msg_end |-> run_last)
        else $error("end word without run_last");

    // The end word carries no byte
    a_end_byte: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && msg_end |-> out_byte == 8'd0)
        else $error("end word with nonzero byte");

    // Byte words carry no count
    a_byte_count: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && !msg_end |-> out_count == 16'd0)
        else $error("byte word with nonzero count");

endmodule

bind telnet_aware_hangul_noise_filter thnf_checker u_thnf_checker (.*);

@@ tb/telnet_aware_hangul_noise_filter_tb.sv @@
// Self-checking testbench of the telnet-aware Hangul noise filter.
// Drives directed and random message bytes, predicts each result word and
// checks it in order; depends on thnf_pkg and telnet_aware_hangul_noise_filter.
module telnet_aware_hangul_noise_filter_tb;

    localparam int DIR_ROWS      = 26;
    localparam int DRAIN_CYCLES  = 20;
    localparam int RX_HOLD       = 300;
    localparam int CYCLE_LIMIT   = 1000000;

    typedef enum logic [1:0] {FM_READY, FM_LEAD, FM_IAC, FM_OPTION} filt_mode_t;

    // One result word as the block shows it
    typedef struct packed {
        logic [7:0]           data;
        logic                 run_last;
        logic                 msg_end;
        thnf_pkg::count_out_t count;
    } result_word_t;

    // One input byte; typed rows carry their expected words
    typedef struct packed {
        logic [7:0]           data;
        logic                 last;
        logic                 typed;
        logic [1:0]           nbytes;
        logic [7:0]           e0;
        logic [7:0]           e1;
        thnf_pkg::count_out_t ecnt;
    } byte_row_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [7:0]  cfg_data;
    logic        push;
    logic        full;
    logic [7:0]  in_byte;
    logic        in_last;
    logic        empty;
    logic        pop;
    logic [7:0]  out_byte;
    logic        run_last;
    logic        msg_end;
    logic [15:0] out_count;

    // Filter state mirrored by the predictor
    filt_mode_t       fm_mode;
    logic [7:0]       fm_held;
    thnf_pkg::count_t fm_count;
    logic [7:0]       fm_cmd_min;

    result_word_t step_words [0:2];
    int           step_n;
    result_word_t expected_words [$];
    byte_row_t    dir_rows [0:DIR_ROWS-1];

    int tx_idle_pct;
    int rx_idle_pct;
    bit rx_hold_req;
    int useful_items;
    int fail_count;
    int cycles;

    telnet_aware_hangul_noise_filter dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .push      (push),
        .full      (full),
        .in_byte   (in_byte),
        .in_last   (in_last),
        .empty     (empty),
        .pop       (pop),
        .out_byte  (out_byte),
        .run_last  (run_last),
        .msg_end   (msg_end),
        .out_count (out_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic bit is_text(input logic [7:0] b);
        return (b >= thnf_pkg::TEXT_MIN && b <= thnf_pkg::TEXT_MAX) ||
               b == thnf_pkg::CHAR_NL || b == thnf_pkg::CHAR_CR ||
               b == thnf_pkg::CHAR_TAB;
    endfunction

    // Add one byte word and bump the saturating count
    function automatic void emit_byte(input logic [7:0] b);
        step_words[step_n] = '{b, 1'b0, 1'b0, '0};
        step_n++;
        if (fm_count != thnf_pkg::COUNT_MAX)
            fm_count++;
    endfunction

    function automatic void filter_ready(input logic [7:0] b);
        if (b == thnf_pkg::BYTE_IAC)
        begin
            fm_held = thnf_pkg::BYTE_IAC;
            fm_mode = FM_IAC;
        end
        else if (is_text(b))
            emit_byte(b);
        else if (b >= thnf_pkg::LEAD_MIN && b <= thnf_pkg::LEAD_MAX)
        begin
            fm_held = b;
            fm_mode = FM_LEAD;
        end
    endfunction

    // Work out the words one accepted byte causes into step_words
    function automatic void filter_byte(input logic [7:0] b, input logic last);
        step_n = 0;
        case (fm_mode)
            FM_LEAD:
            begin
                if (b == thnf_pkg::BYTE_IAC)
                begin
                    fm_held = thnf_pkg::BYTE_IAC;
                    fm_mode = FM_IAC;
                end
                else if (b >= thnf_pkg::LEAD_MIN && b <= thnf_pkg::TRAIL_MAX)
                begin
                    emit_byte(fm_held);
                    emit_byte(b);
                    fm_mode = FM_READY;
                end
                else if (is_text(b))
                begin
                    emit_byte(b);
                    fm_mode = FM_READY;
                end
            end
            FM_IAC:
            begin
                if (b >= fm_cmd_min)
                begin
                    emit_byte(thnf_pkg::BYTE_IAC);
                    emit_byte(b);
                    fm_mode = (b >= thnf_pkg::OPT_CMD_MIN && b <= thnf_pkg::OPT_CMD_MAX)
                            ? FM_OPTION : FM_READY;
                end
                else
                begin
                    fm_mode = FM_READY;
                    filter_ready(b);
                end
            end
            FM_OPTION:
            begin
                emit_byte(b);
                fm_mode = FM_READY;
            end
            default:
                filter_ready(b);
        endcase
        // Close the message: drop anything pending and report the count
        if (last)
        begin
            step_words[step_n] = '{8'h00, 1'b0, 1'b1,
                                   fm_count[thnf_pkg::OUT_COUNT_W-1:0]};
            step_n++;
            fm_mode  = FM_READY;
            fm_held  = '0;
            fm_count = '0;
        end
        if (step_n > 0)
            step_words[step_n-1].run_last = 1'b1;
    endfunction

    function automatic void check_field(input string name, input logic [15:0] want,
                                        input logic [15:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            fail_count++;
        end
    endfunction

    function automatic logic [7:0] random_text();
        case ($urandom_range(0, 11))
            0:       return thnf_pkg::CHAR_NL;
            1:       return thnf_pkg::CHAR_CR;
            2:       return thnf_pkg::CHAR_TAB;
            default: return 8'($urandom_range(thnf_pkg::TEXT_MIN, thnf_pkg::TEXT_MAX));
        endcase
    endfunction

    // Offer one byte at a negedge, hold it until taken, then queue its words
    task automatic send_word(input byte_row_t r);
        filt_mode_t prev_mode;
        while ($urandom_range(0, 99) < tx_idle_pct)
        begin
            push <= 1'b0;
            @(negedge clk);
        end
        push    <= 1'b1;
        in_byte <= r.data;
        in_last <= r.last;
        @(posedge clk);
        while (full)
            @(posedge clk);
        prev_mode = fm_mode;
        filter_byte(r.data, r.last);
        if (step_n > 0 || fm_mode != prev_mode)
            useful_items++;
        // Typed rows replace the predicted words with the ones written down
        if (r.typed)
        begin
            step_n = 0;
            if (r.nbytes > 0)
            begin
                step_words[step_n] = '{r.e0, 1'b0, 1'b0, '0};
                step_n++;
            end
            if (r.nbytes > 1)
            begin
                step_words[step_n] = '{r.e1, 1'b0, 1'b0, '0};
                step_n++;
            end
            if (r.last)
            begin
                step_words[step_n] = '{8'h00, 1'b0, 1'b1, r.ecnt};
                step_n++;
            end
            if (step_n > 0)
                step_words[step_n-1].run_last = 1'b1;
        end
        for (int i = 0; i < step_n; i++)
            expected_words.push_back(step_words[i]);
        @(negedge clk);
    endtask

    task automatic send_byte(input logic [7:0] b);
        byte_row_t r;
        r = '{b, ($urandom_range(0, 11) == 0), 1'b0, 2'd0, 8'h00, 8'h00, '0};
        send_word(r);
    endtask

    // Mostly well-formed sequences with random content, some broken or raw
    task automatic send_phrase();
        int kind;
        logic [7:0] c;
        kind = $urandom_range(0, 99);
        if (kind < 25)
            send_byte(random_text());
        else if (kind < 45)
        begin
            send_byte(8'($urandom_range(thnf_pkg::LEAD_MIN, thnf_pkg::LEAD_MAX)));
            send_byte(8'($urandom_range(thnf_pkg::LEAD_MIN, thnf_pkg::TRAIL_MAX)));
        end
        else if (kind < 52)
        begin
            send_byte(8'($urandom_range(thnf_pkg::LEAD_MIN, thnf_pkg::LEAD_MAX)));
            send_byte($urandom_range(0, 1) ? 8'($urandom_range(0, 8))
                                           : 8'($urandom_range(8'h7f, 8'h9f)));
            send_byte(8'($urandom_range(thnf_pkg::LEAD_MIN, thnf_pkg::TRAIL_MAX)));
        end
        else if (kind < 58)
        begin
            send_byte(8'($urandom_range(thnf_pkg::LEAD_MIN, thnf_pkg::LEAD_MAX)));
            send_byte(random_text());
        end
        else if (kind < 73)
        begin
            send_byte(thnf_pkg::BYTE_IAC);
            c = $urandom_range(0, 1)
              ? 8'($urandom_range(thnf_pkg::OPT_CMD_MIN, thnf_pkg::OPT_CMD_MAX))
              : 8'($urandom_range(fm_cmd_min, 255));
            send_byte(c);
            if (c >= thnf_pkg::OPT_CMD_MIN && c <= thnf_pkg::OPT_CMD_MAX)
                send_byte(8'($urandom_range(0, 255)));
        end
        else if (kind < 80)
        begin
            send_byte(thnf_pkg::BYTE_IAC);
            send_byte(8'($urandom_range(0, 255)));
        end
        else if (kind < 85)
        begin
            send_byte(thnf_pkg::BYTE_IAC);
            send_byte(thnf_pkg::BYTE_IAC);
        end
        else
            send_byte(8'($urandom_range(0, 255)));
    endtask

    task automatic run_random(input int target);
        int start;
        start = useful_items;
        while (useful_items - start < target)
            send_phrase();
    endtask

    // Drop push, wait for every expected word, then let the pipeline empty
    task automatic settle();
        push <= 1'b0;
        while (expected_words.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_cmd_min(input logic [7:0] v);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        fm_cmd_min = v;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Receiver: pop at random, check each word taken against the oldest expectation
    initial
    begin
        result_word_t w;
        wait (rst_n === 1'b1);
        @(negedge clk);
        forever
        begin
            // Hold off for a long stretch so the block fills and stalls its input
            if (rx_hold_req)
            begin
                pop <= 1'b0;
                repeat (RX_HOLD) @(negedge clk);
                rx_hold_req = 1'b0;
            end
            pop <= ($urandom_range(0, 99) >= rx_idle_pct);
            @(posedge clk);
            if (pop === 1'b1 && empty === 1'b0)
            begin
                if (expected_words.size() == 0)
                begin
                    $display("%0t: unexpected word, expected none, actual byte %0h end %0b count %0h",
                             $time, out_byte, msg_end, out_count);
                    fail_count++;
                end
                else
                begin
                    w = expected_words.pop_front();
                    // Compare every field of the word
                    check_field("out_byte", 16'(w.data), 16'(out_byte));
                    check_field("run_last", 16'(w.run_last), 16'(run_last));
                    check_field("msg_end", 16'(w.msg_end), 16'(msg_end));
                    check_field("out_count", w.count, out_count);
                end
            end
            @(negedge clk);
        end
    end

    // Stop a hung run
    initial
    begin
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("status: fail");
        $finish;
    end

    initial
    begin
        rst_n       = 1'b0;
        cfg_valid   = 1'b0;
        cfg_data    = 8'h00;
        push        = 1'b0;
        in_byte     = 8'h00;
        in_last     = 1'b0;
        pop         = 1'b0;
        rx_hold_req = 1'b0;
        useful_items = 0;
        fail_count  = 0;
        fm_mode     = FM_READY;
        fm_held     = '0;
        fm_count    = '0;
        fm_cmd_min  = thnf_pkg::CMD_MIN_RESET;

        // data, last, typed, nbytes, e0, e1, ecnt
        dir_rows = '{
            '{8'h20, 1'b0, 1'b1, 2'd1, 8'h20, 8'h00, 16'd0},  // lowest printable
            '{8'h00, 1'b0, 1'b1, 2'd0, 8'h00, 8'h00, 16'd0},  // zero is noise
            '{8'h7e, 1'b0, 1'b1, 2'd1, 8'h7e, 8'h00, 16'd0},  // highest printable
            '{8'h0a, 1'b0, 1'b0, 2'd0, 8'h00, 8'h00, 16'd0},
            '{8'h09, 1'b0, 1'b0, 2'd0, 8'h00, 8'h00, 16'd0},
            '{8'ha0, 1'b0, 1'b0, 2'd0, 8'h00, 8'h00, 16'd0},  // lowest lead
            '{8'hfe, 1'b0, 1'b0, 2'd0, 8'h00, 8'h00, 16'd0},  // highest trail
            '{8'hc8, 1'b0, 1'b0, 2'd0, 8'h00, 8'h00, 16'd0},  // highest lead
            '{8'h05, 1'b0, 1'b0, 2'd0, 8'h00, 8'h00, 16'd0},  // noise keeps the lead
            '{8'h41, 1'b0, 1'b0, 2'd0, 8'h00, 8'h00, 16'd0},  // text drops the lead
            '{8'ha5, 1'b0, 1'b0, 2'd0, 8'h00, 8'h00, 16'd0},
            '{8'hff, 1'b0, 1'b0, 2'd0, 8'h00, 8'h00, 16'd0},  // IAC drops the lead
            '{8'hf4, 1'b0, 1'b0, 2'd0, 8'h00, 8'h00, 16'd0},
            '{8'hff, 1'b0, 1'b0, 2'd0, 8'h00, 8'h00, 16'd0},
            '{8'hfb, 1'b0, 1'b0, 2'd0, 8'h00, 8'h00, 16'd0},  // WILL waits for an option
            '{8'h00, 1'b0, 1'b0, 2'd0, 8'h00, 8'h00, 16'd0},  // option passes as is
            '{8'hff, 1'b0, 1'b0, 2'd0, 8'h00, 8'h00, 16'd0},
            '{8'h41, 1'b0, 1'b0, 2'd0, 8'h00, 8'h00, 16'd0},  // non-command after IAC
            '{8'hff, 1'b0, 1'b0, 2'd0, 8'h00, 8'h00, 16'd0},
            '{8'hff, 1'b0, 1'b0, 2'd0, 8'h00, 8'h00, 16'd0},  // escaped IAC
            '{8'hc9, 1'b0, 1'b0, 2'd0, 8'h00, 8'h00, 16'd0},  // just above the lead range
            '{8'ha0, 1'b1, 1'b0, 2'd0, 8'h00, 8'h00, 16'd0},  // lead pending at end
            '{8'hff, 1'b1, 1'b1, 2'd0, 8'h00, 8'h00, 16'd0},  // IAC pending at end
            '{8'hff, 1'b0, 1'b0, 2'd0, 8'h00, 8'h00, 16'd0},
            '{8'hfd, 1'b1, 1'b1, 2'd2, 8'hff, 8'hfd, 16'd2},  // option pending at end
            '{8'h61, 1'b0, 1'b1, 2'd1, 8'h61, 8'h00, 16'd0}   // back in ready mode
        };

        repeat (10) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed bytes with the reset command threshold
        tx_idle_pct = 7;
        rx_idle_pct = 84;
        for (int i = 0; i < DIR_ROWS; i++)
            send_word(dir_rows[i]);

        // Every byte after IAC is a command
        settle();
        write_cmd_min(8'd0);
        run_random(70);

        // Only an escaped IAC is a command
        settle();
        tx_idle_pct = 84;
        rx_idle_pct = 7;
        write_cmd_min(8'd255);
        run_random(70);

        // Random thresholds, no idling, one long receiver stall
        settle();
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        write_cmd_min(8'($urandom_range(0, 255)));
        rx_hold_req = 1'b1;
        run_random(60);
        settle();
        write_cmd_min(8'($urandom_range(240, 255)));
        run_random(60);

        settle();
        if (fail_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

@@ files.f @@
src/thnf_pkg.sv
src/thnf_front.sv
src/thnf_queue.sv
src/thnf_back.sv
src/telnet_aware_hangul_noise_filter.sv
src/thnf_checker.sv
tb/telnet_aware_hangul_noise_filter_tb.sv
